// ===== rtl/bltf_pkg.sv =====
// ----------------------------------------------------------------------------
// bltf_pkg
// Shared constants, types and store-layout helpers for the bilinear texel
// filter with repeat wrap.
// ----------------------------------------------------------------------------
package bltf_pkg;

   localparam int MAX_SIZE_LOG2 = 7;
   localparam int FRAC_BITS     = 16;
   localparam int NUM_LEVELS    = 8;
   localparam int LEVEL_W       = 3;
   localparam int SIDE_W        = MAX_SIZE_LOG2;
   localparam int LOG_W         = $clog2(MAX_SIZE_LOG2 + 1);
   localparam int CSR_W         = 3;
   localparam int COORD_W       = FRAC_BITS + 1;
   localparam int SCALED_W      = COORD_W + SIDE_W;
   localparam int OFF_W         = 2 * SIDE_W;
   localparam int TEXEL_W       = 32;
   localparam int NUM_CHAN      = 4;
   localparam int NUM_BANKS     = 4;
   localparam int WEIGHT_W      = 2 * COORD_W;
   localparam int PROD_W        = WEIGHT_W + 8;
   localparam int SUM_W         = PROD_W + 2;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef enum logic {
      CSR_WIDTH_LOG2  = 1'b0,
      CSR_HEIGHT_LOG2 = 1'b1
   } csr_index_type;

   // side log2 of a level's region
   function automatic int side_int(input int l);
      return (l >= MAX_SIZE_LOG2) ? 0 : (MAX_SIZE_LOG2 - l);
   endfunction

   // start of a level's region inside each bank
   function automatic int base4_int(input int l);
      int off;
      int s;
      off = 0;
      for (int k = 0; k < l; k++) begin
         s = side_int(k);
         off += (s == 0) ? 1 : (1 << (2 * (s - 1)));
      end
      return off;
   endfunction

   localparam int BANK_DEPTH = base4_int(NUM_LEVELS);
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   function automatic logic [LOG_W-1:0] side_of(input logic [LEVEL_W-1:0] l);
      return LOG_W'(side_int(int'(l)));
   endfunction

   function automatic logic [BANK_AW-1:0] level_base(input logic [LEVEL_W-1:0] l);
      logic [BANK_AW-1:0] res;
      res = '0;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         if (int'(l) == k) res = BANK_AW'(base4_int(k));
      end
      return res;
   endfunction

   // entry of texel (x, y) inside its bank, relative to the level's region
   function automatic logic [BANK_AW-1:0] bank_offset(input logic [SIDE_W-1:0] x,
                                                      input logic [SIDE_W-1:0] y,
                                                      input logic [LOG_W-1:0]  s);
      logic [OFF_W-1:0] off;
      off = '0;
      if (s != '0) begin
         off = (OFF_W'(y >> 1) << (s - LOG_W'(1))) | OFF_W'(x >> 1);
      end
      return BANK_AW'(off);
   endfunction

   typedef struct packed {
      logic                 valid;
      logic [FRAC_BITS-1:0] fx;
      logic [FRAC_BITS-1:0] fy;
   } smp_type;

endpackage

// ===== rtl/bilinear_texel_filter_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_texel_filter_repeat_unit
// Bilinear RGBA8 texel filter with repeat wrap over a mip chain.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item. req_tuser is func: a write word stores
//   one texel of a mip level and gives no result; a sample word gives one
//   rsp_* word holding the filtered red, green, blue and alpha channels.
//   csr_* sets the base width and height log2 between bursts of work.
// Throughput: one word per cycle while the output is not stalled, writes and samples
//   freely mixed. The texel store is split into four banks by texel row and
//   column parity, so the four neighbors of a sample are read in the same cycle.
// Pipeline: a sample passes the registered steps scale at accept, bank read,
//   weights, products, and sum and round before its result shows on rsp_tvalid.
// Ordering: writes and reads go out from the same stage in order, so a
//   sample sees every write accepted before it.
// Reset: clears the pipeline valids and sets both log2 registers to 7.
//   Texel contents are undefined until written.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module bilinear_texel_filter_repeat_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // level[2:0], tex_x[9:3], tex_y[16:10], texel[48:17], coord_u[65:49],
   // coord_v[82:66], zero fill [87:83]
   input  logic [87:0] req_tdata,
   // func[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [bltf_pkg::CSR_W-1:0] csr_wdata
);

   logic                        adv;
   logic [bltf_pkg::LOG_W-1:0]  width_log2_ff, width_log2_in;
   logic [bltf_pkg::LOG_W-1:0]  height_log2_ff, height_log2_in;
   logic [bltf_pkg::LOG_W-1:0]  csr_sat;

   // advance everything unless a finished word waits on the receiver
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // saturate register writes to the largest level size
   always_comb begin
      csr_sat = (int'(csr_wdata) > bltf_pkg::MAX_SIZE_LOG2) ?
                bltf_pkg::LOG_W'(bltf_pkg::MAX_SIZE_LOG2) : bltf_pkg::LOG_W'(csr_wdata);
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      if (csr_we) begin
         case (bltf_pkg::csr_index_type'(csr_index))
            bltf_pkg::CSR_WIDTH_LOG2:  width_log2_in  = csr_sat;
            bltf_pkg::CSR_HEIGHT_LOG2: height_log2_in = csr_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= bltf_pkg::LOG_W'(bltf_pkg::MAX_SIZE_LOG2);
         height_log2_ff <= bltf_pkg::LOG_W'(bltf_pkg::MAX_SIZE_LOG2);
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
      end
   end

   bltf_pkg::smp_type            smp;
   logic [bltf_pkg::TEXEL_W-1:0] taps [bltf_pkg::NUM_BANKS];

   bltf_fetch u_fetch (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_tvalid),
      .func        (req_tuser),
      .level       (req_tdata[2:0]),
      .tex_x       (req_tdata[9:3]),
      .tex_y       (req_tdata[16:10]),
      .texel       (req_tdata[48:17]),
      .coord_u     (req_tdata[65:49]),
      .coord_v     (req_tdata[82:66]),
      .width_log2  (width_log2_ff),
      .height_log2 (height_log2_ff),
      .smp         (smp),
      .taps        (taps)
   );

   bltf_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .smp       (smp),
      .taps      (taps),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

endmodule

// ===== rtl/bltf_bank_ram.sv =====
// ----------------------------------------------------------------------------
// bltf_bank_ram
// Single-port synchronous RAM with a registered read that holds while not
// enabled or while writing.
// ----------------------------------------------------------------------------
module bltf_bank_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          en,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bltf_fetch.sv =====
// ----------------------------------------------------------------------------
// bltf_fetch
// Coordinate scaling, wrap and bank addressing over a four-bank texel
// store; issues texel writes and the four neighbor reads of a sample.
// ----------------------------------------------------------------------------
module bltf_fetch (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic                                 func,
   input  logic [bltf_pkg::LEVEL_W-1:0]         level,
   input  logic [bltf_pkg::SIDE_W-1:0]          tex_x,
   input  logic [bltf_pkg::SIDE_W-1:0]          tex_y,
   input  logic [bltf_pkg::TEXEL_W-1:0]         texel,
   input  logic [bltf_pkg::COORD_W-1:0]         coord_u,
   input  logic [bltf_pkg::COORD_W-1:0]         coord_v,
   input  logic [bltf_pkg::LOG_W-1:0]           width_log2,
   input  logic [bltf_pkg::LOG_W-1:0]           height_log2,
   output bltf_pkg::smp_type                    smp,
   output logic [bltf_pkg::TEXEL_W-1:0]         taps [bltf_pkg::NUM_BANKS]
);

   localparam int F = bltf_pkg::FRAC_BITS;

   // stage 0: scale and write address
   logic [bltf_pkg::LOG_W-1:0]    wl, hl, ws;
   logic [bltf_pkg::SIDE_W-1:0]   wmask, hmask, smask, wx, wy;

   always_comb begin
      wl = bltf_pkg::LOG_W'((int'(width_log2) > int'(level)) ?
                            int'(width_log2) - int'(level) : 0);
      hl = bltf_pkg::LOG_W'((int'(height_log2) > int'(level)) ?
                            int'(height_log2) - int'(level) : 0);
      wmask = (bltf_pkg::SIDE_W'(1) << wl) - bltf_pkg::SIDE_W'(1);
      hmask = (bltf_pkg::SIDE_W'(1) << hl) - bltf_pkg::SIDE_W'(1);
      ws    = bltf_pkg::side_of(level);
      smask = (bltf_pkg::SIDE_W'(1) << ws) - bltf_pkg::SIDE_W'(1);
      wx    = tex_x & smask;
      wy    = tex_y & smask;
   end

   logic                            p1_v_ff, p1_v_in;
   logic                            p1_func_ff;
   logic [bltf_pkg::LEVEL_W-1:0]    p1_level_ff;
   logic [bltf_pkg::LOG_W-1:0]      p1_side_ff;
   logic [bltf_pkg::BANK_AW-1:0]    p1_waddr_ff;
   logic [1:0]                      p1_wbank_ff;
   logic [bltf_pkg::TEXEL_W-1:0]    p1_texel_ff;
   logic [bltf_pkg::SCALED_W-1:0]   p1_su_ff, p1_sv_ff;
   logic [bltf_pkg::SIDE_W-1:0]     p1_wmask_ff, p1_hmask_ff;

   assign p1_v_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= p1_v_in;
      end
      if (adv) begin
         p1_func_ff  <= func;
         p1_level_ff <= level;
         p1_side_ff  <= ws;
         p1_waddr_ff <= bltf_pkg::level_base(level) + bltf_pkg::bank_offset(wx, wy, ws);
         p1_wbank_ff <= {wy[0], wx[0]};
         p1_texel_ff <= texel;
         p1_su_ff    <= bltf_pkg::SCALED_W'(coord_u) * bltf_pkg::SCALED_W'(wmask);
         p1_sv_ff    <= bltf_pkg::SCALED_W'(coord_v) * bltf_pkg::SCALED_W'(hmask);
         p1_wmask_ff <= wmask;
         p1_hmask_ff <= hmask;
      end
   end

   // stage 1: wrap neighbors, route each to its bank
   logic [bltf_pkg::SIDE_W-1:0]   x0, x1, y0, y1;
   logic [bltf_pkg::SIDE_W-1:0]   bx [bltf_pkg::NUM_BANKS];
   logic [bltf_pkg::SIDE_W-1:0]   by [bltf_pkg::NUM_BANKS];
   logic [bltf_pkg::BANK_AW-1:0]  addr [bltf_pkg::NUM_BANKS];
   logic [bltf_pkg::NUM_BANKS-1:0] en, we;
   logic [bltf_pkg::TEXEL_W-1:0]  rdata [bltf_pkg::NUM_BANKS];
   logic                          is_wr;

   always_comb begin
      x0 = p1_su_ff[F +: bltf_pkg::SIDE_W] & p1_wmask_ff;
      y0 = p1_sv_ff[F +: bltf_pkg::SIDE_W] & p1_hmask_ff;
      x1 = (x0 + bltf_pkg::SIDE_W'(1)) & p1_wmask_ff;
      y1 = (y0 + bltf_pkg::SIDE_W'(1)) & p1_hmask_ff;
      is_wr = (p1_func_ff == bltf_pkg::FUNC_WRITE);
      for (int b = 0; b < bltf_pkg::NUM_BANKS; b++) begin
         bx[b] = (x0[0] == b[0]) ? x0 : x1;
         by[b] = (y0[0] == b[1]) ? y0 : y1;
         we[b] = adv && p1_v_ff && is_wr && (p1_wbank_ff == 2'(b));
         en[b] = adv && p1_v_ff && (!is_wr || (p1_wbank_ff == 2'(b)));
         addr[b] = is_wr ? p1_waddr_ff :
                   bltf_pkg::level_base(p1_level_ff) +
                   bltf_pkg::bank_offset(bx[b], by[b], p1_side_ff);
      end
   end

   for (genvar g = 0; g < bltf_pkg::NUM_BANKS; g++) begin : g_bank
      bltf_bank_ram #(
         .DEPTH (bltf_pkg::BANK_DEPTH),
         .AW    (bltf_pkg::BANK_AW),
         .DW    (bltf_pkg::TEXEL_W)
      ) u_ram (
         .clock (clock),
         .en    (en[g]),
         .we    (we[g]),
         .addr  (addr[g]),
         .wdata (p1_texel_ff),
         .rdata (rdata[g])
      );
   end

   // stage 2: read data lands beside the fractions
   bltf_pkg::smp_type p2_ff, p2_in;
   logic [3:0]        p2_par_ff;

   always_comb begin
      p2_in.valid = p1_v_ff && !is_wr;
      p2_in.fx    = p1_su_ff[F-1:0];
      p2_in.fy    = p1_sv_ff[F-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (adv) begin
         p2_ff.valid <= p2_in.valid;
      end
      if (adv) begin
         p2_ff.fx  <= p2_in.fx;
         p2_ff.fy  <= p2_in.fy;
         p2_par_ff <= {y1[0], y0[0], x1[0], x0[0]};
      end
   end

   assign smp     = p2_ff;
   assign taps[0] = rdata[{p2_par_ff[2], p2_par_ff[0]}];
   assign taps[1] = rdata[{p2_par_ff[2], p2_par_ff[1]}];
   assign taps[2] = rdata[{p2_par_ff[3], p2_par_ff[0]}];
   assign taps[3] = rdata[{p2_par_ff[3], p2_par_ff[1]}];

   a_we_onehot: assert property (@(posedge clock) disable iff (reset) $onehot0(we))
      else $error("more than one bank written");
   a_wr_no_smp: assert property (@(posedge clock) disable iff (reset)
      (|we) |=> !p2_ff.valid)
      else $error("write item entered the sample path");
   a_rd_all: assert property (@(posedge clock) disable iff (reset)
      (adv && p1_v_ff && !is_wr) |-> (&en))
      else $error("sample did not read all banks");

endmodule

// ===== rtl/bltf_blend.sv =====
// ----------------------------------------------------------------------------
// bltf_blend
// Bilinear weights, per-channel products, sum and rounding into the
// output register.
// ----------------------------------------------------------------------------
module bltf_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  bltf_pkg::smp_type             smp,
   input  logic [bltf_pkg::TEXEL_W-1:0]  taps [bltf_pkg::NUM_BANKS],
   output logic                          out_valid,
   output logic [bltf_pkg::TEXEL_W-1:0]  out_data
);

   localparam int F = bltf_pkg::FRAC_BITS;
   localparam logic [bltf_pkg::COORD_W-1:0] ONE  = bltf_pkg::COORD_W'(1) << F;
   localparam logic [bltf_pkg::SUM_W-1:0]   HALF = bltf_pkg::SUM_W'(1) << (2 * F - 1);

   logic [bltf_pkg::COORD_W-1:0]  fx, fy, ofx, ofy;
   logic [bltf_pkg::WEIGHT_W-1:0] w_in [4];

   always_comb begin
      fx  = bltf_pkg::COORD_W'(smp.fx);
      fy  = bltf_pkg::COORD_W'(smp.fy);
      ofx = ONE - fx;
      ofy = ONE - fy;
      w_in[0] = bltf_pkg::WEIGHT_W'(ofx) * bltf_pkg::WEIGHT_W'(ofy);
      w_in[1] = bltf_pkg::WEIGHT_W'(fx)  * bltf_pkg::WEIGHT_W'(ofy);
      w_in[2] = bltf_pkg::WEIGHT_W'(ofx) * bltf_pkg::WEIGHT_W'(fy);
      w_in[3] = bltf_pkg::WEIGHT_W'(fx)  * bltf_pkg::WEIGHT_W'(fy);
   end

   logic                          p3_v_ff, p4_v_ff, out_v_ff;
   logic [bltf_pkg::WEIGHT_W-1:0] p3_w_ff [4];
   logic [bltf_pkg::TEXEL_W-1:0]  p3_t_ff [4];
   logic [bltf_pkg::PROD_W-1:0]   p4_prod_ff [bltf_pkg::NUM_CHAN][4];
   logic [bltf_pkg::TEXEL_W-1:0]  out_data_ff, out_data_in;
   logic [bltf_pkg::SUM_W-1:0]    acc, rsh;

   always_comb begin
      for (int c = 0; c < bltf_pkg::NUM_CHAN; c++) begin
         acc = HALF;
         for (int k = 0; k < 4; k++) begin
            acc = acc + bltf_pkg::SUM_W'(p4_prod_ff[c][k]);
         end
         rsh = acc >> (2 * F);
         out_data_in[8*c +: 8] = (rsh > bltf_pkg::SUM_W'(255)) ? 8'hFF : rsh[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         p3_v_ff  <= smp.valid;
         p4_v_ff  <= p3_v_ff;
         out_v_ff <= p4_v_ff;
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            p3_w_ff[k] <= w_in[k];
            p3_t_ff[k] <= taps[k];
         end
         for (int c = 0; c < bltf_pkg::NUM_CHAN; c++) begin
            for (int k = 0; k < 4; k++) begin
               p4_prod_ff[c][k] <= bltf_pkg::PROD_W'(p3_t_ff[k][8*c +: 8]) *
                                   bltf_pkg::PROD_W'(p3_w_ff[k]);
            end
         end
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bilinear_texel_filter_repeat_unit: fills the texels
// that samples can reach, runs a table of directed words, then random writes
// and samples under several size settings, checked against a behavioral
// filter or the table's expected colors.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STORE_SIZE = 21845;
   localparam int LIMIT      = 60000;
   localparam int PHASE_WORDS = 160;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [bltf_pkg::CSR_W-1:0] csr_wdata = '0;

   bilinear_texel_filter_repeat_unit u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   always #5 clock = ~clock;

   // behavioral copy of the texel store and size registers
   logic [31:0] texel_mem [0:STORE_SIZE-1];
   logic [2:0]  size_w_log2 = 3'd7;
   logic [2:0]  size_h_log2 = 3'd7;
   logic [31:0] pending_rgba [$];
   int          errors = 0;
   int          cycles = 0;
   bit          no_idle = 1'b0;

   typedef struct {
      bltf_pkg::func_type func;
      logic [2:0]  level;
      logic [6:0]  tx;
      logic [6:0]  ty;
      logic [31:0] texel;
      logic [16:0] cu;
      logic [16:0] cv;
      bit          known;
      logic [31:0] rgba;
   } stim_row_type;

   stim_row_type directed [0:15];

   function automatic int region_log2(input int lvl);
      return (lvl >= bltf_pkg::MAX_SIZE_LOG2) ? 0 : bltf_pkg::MAX_SIZE_LOG2 - lvl;
   endfunction

   function automatic int region_addr(input int lvl, input int x, input int y);
      int off;
      off = 0;
      for (int k = 0; k < lvl; k++) off += 1 << (2 * region_log2(k));
      return off + ((y << region_log2(lvl)) | x);
   endfunction

   // base-level rows and columns that the directed samples touch
   function automatic bit probe_pos(input int c);
      return c inside {0, 1, 63, 64, 126, 127};
   endfunction

   // exact bilinear blend with repeat wrap, rounded half up per channel
   function automatic logic [31:0] filter_rgba(input int lvl, input logic [16:0] cu,
                                               input logic [16:0] cv);
      longint unsigned wmask, hmask, su, sv, fx, fy, acc, r;
      longint unsigned w [4];
      int x0, y0, x1, y1;
      logic [31:0] t [4];
      logic [31:0] res;
      wmask = (64'd1 << ((size_w_log2 > lvl) ? size_w_log2 - lvl : 0)) - 1;
      hmask = (64'd1 << ((size_h_log2 > lvl) ? size_h_log2 - lvl : 0)) - 1;
      su = cu * wmask;
      sv = cv * hmask;
      fx = su & 64'hFFFF;
      fy = sv & 64'hFFFF;
      x0 = int'((su >> 16) & wmask);
      y0 = int'((sv >> 16) & hmask);
      x1 = int'((x0 + 1) & wmask);
      y1 = int'((y0 + 1) & hmask);
      t[0] = texel_mem[region_addr(lvl, x0, y0)];
      t[1] = texel_mem[region_addr(lvl, x1, y0)];
      t[2] = texel_mem[region_addr(lvl, x0, y1)];
      t[3] = texel_mem[region_addr(lvl, x1, y1)];
      w[0] = (65536 - fx) * (65536 - fy);
      w[1] = fx * (65536 - fy);
      w[2] = (65536 - fx) * fy;
      w[3] = fx * fy;
      for (int ch = 0; ch < 4; ch++) begin
         acc = 0;
         for (int n = 0; n < 4; n++) acc += longint'(t[n][ch*8 +: 8]) * w[n];
         r = (acc + (64'd1 << 31)) >> 32;
         res[ch*8 +: 8] = (r > 255) ? 8'd255 : r[7:0];
      end
      return res;
   endfunction

   // update the store or queue the filtered color for one accepted word
   function automatic void track_word(input stim_row_type w);
      int s;
      if (w.func == bltf_pkg::FUNC_WRITE) begin
         s = region_log2(w.level);
         texel_mem[region_addr(w.level, w.tx & ((1 << s) - 1), w.ty & ((1 << s) - 1))]
            = w.texel;
      end else begin
         pending_rgba.push_back(w.known ? w.rgba : filter_rgba(w.level, w.cu, w.cv));
      end
   endfunction

   // present one word, idling at random first, and hold it until taken
   task automatic send_word(input stim_row_type w);
      bit taken;
      while (!no_idle && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.func;
      req_tdata  <= {5'b0, w.cv, w.cu, w.texel, w.ty, w.tx, w.level};
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         if (taken) track_word(w);
         @(posedge clock);
      end
   endtask

   // drop valid, wait for every color, then let trailing writes settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_rgba.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input bltf_pkg::csr_index_type idx,
                            input logic [bltf_pkg::CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == bltf_pkg::CSR_WIDTH_LOG2) size_w_log2 = val;
      else size_h_log2 = val;
   endtask

   // samples stay on levels whose whole region is loaded
   function automatic stim_row_type random_word;
      stim_row_type w;
      int pick;
      w.func  = ($urandom_range(99) < 30) ? bltf_pkg::FUNC_WRITE : bltf_pkg::FUNC_SAMPLE;
      w.level = (w.func == bltf_pkg::FUNC_WRITE) ? 3'($urandom_range(7)) :
                3'($urandom_range(7, 3));
      w.tx    = 7'($urandom);
      w.ty    = 7'($urandom);
      w.texel = $urandom;
      pick = $urandom_range(9);
      w.cu = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 : 17'($urandom_range(65536));
      pick = $urandom_range(9);
      w.cv = (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 : 17'($urandom_range(65536));
      w.known = 1'b0;
      w.rgba  = '0;
      return w;
   endfunction

   // result side: stall at random, compare each taken color with the oldest
   always @(posedge clock) begin
      rsp_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
   end

   always @(negedge clock) begin
      logic [31:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rgba.size() == 0) begin
            $display("%0t: unexpected color %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_rgba.pop_front();
            for (int ch = 0; ch < 4; ch++) begin
               if (rsp_tdata[ch*8 +: 8] !== want[ch*8 +: 8]) begin
                  $display("%0t: channel %0d expected %h actual %h", $time, ch,
                           want[ch*8 +: 8], rsp_tdata[ch*8 +: 8]);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      stim_row_type w;
      logic [2:0] cfg_w [0:5];
      logic [2:0] cfg_h [0:5];
      cfg_w = '{3'd0, 3'd7, 3'd0, 3'd2, 3'd7, 3'd4};
      cfg_h = '{3'd0, 3'd0, 3'd7, 3'd5, 3'd7, 3'd1};
      // level 7 is one texel, so its color reads straight off the write
      directed = '{
         '{bltf_pkg::FUNC_WRITE,  3'd7, 7'd0,   7'd0,   32'hFFFFFFFF, 17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd7, 7'd0,   7'd0,   32'h0,        17'd0,     17'd0,
           1, 32'hFFFFFFFF},
         '{bltf_pkg::FUNC_SAMPLE, 3'd7, 7'd0,   7'd0,   32'h0,        17'd65536, 17'd65536,
           1, 32'hFFFFFFFF},
         '{bltf_pkg::FUNC_WRITE,  3'd7, 7'd127, 7'd127, 32'h0,        17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd7, 7'd0,   7'd0,   32'h0,        17'd32768, 17'd32768,
           1, 0},
         '{bltf_pkg::FUNC_WRITE,  3'd0, 7'd127, 7'd127, 32'h80FF0001, 17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_WRITE,  3'd0, 7'd0,   7'd0,   32'h12345678, 17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd0, 7'd0,   7'd0,   32'h0,        17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd0, 7'd0,   7'd0,   32'h0,        17'd65536, 17'd65536,
           1, 32'h80FF0001},
         '{bltf_pkg::FUNC_SAMPLE, 3'd0, 7'd0,   7'd0,   32'h0,        17'd32768, 17'd32768,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd0, 7'd0,   7'd0,   32'h0,        17'd65535, 17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd6, 7'd0,   7'd0,   32'h0,        17'd65536, 17'd0,
           0, 0},
         '{bltf_pkg::FUNC_WRITE,  3'd3, 7'd127, 7'd5,   32'hA5A5A5A5, 17'd0,     17'd0,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd3, 7'd0,   7'd0,   32'h0,        17'd65535, 17'd45000,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd5, 7'd0,   7'd0,   32'h0,        17'd1,     17'd65535,
           0, 0},
         '{bltf_pkg::FUNC_SAMPLE, 3'd7, 7'd0,   7'd0,   32'h0,        17'd12345, 17'd54321,
           1, 0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load levels 3 to 7 whole and the base-level texels the table reads,
      // so no sample reads an empty entry
      w.func = bltf_pkg::FUNC_WRITE;
      w.cu = '0;
      w.cv = '0;
      w.known = 1'b0;
      w.rgba = '0;
      for (int l = 0; l < 8; l++) begin
         for (int y = 0; y < (1 << region_log2(l)); y++) begin
            for (int x = 0; x < (1 << region_log2(l)); x++) begin
               if (l >= 3 || (l == 0 && probe_pos(x) && probe_pos(y))) begin
                  w.level = 3'(l);
                  w.tx = 7'(x);
                  w.ty = 7'(y);
                  w.texel = $urandom;
                  send_word(w);
               end
            end
         end
      end

      foreach (directed[i]) send_word(directed[i]);

      // one phase per size setting; the drain before each write also
      // holds the sender until the pipeline is empty
      for (int p = 0; p < 6; p++) begin
         drain();
         write_csr(bltf_pkg::CSR_WIDTH_LOG2, cfg_w[p]);
         write_csr(bltf_pkg::CSR_HEIGHT_LOG2, cfg_h[p]);
         no_idle = (p == 4);
         for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word());
      end
      no_idle = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
